// ----- hw/rtl/maus_pkg.sv -----
// ----------------------------------------------------------------------------
// maus_pkg
// Shared widths, operation codes and reduction helpers for the modular unit.
// ----------------------------------------------------------------------------
package maus_pkg;

  localparam int unsigned W = 63;
  localparam int unsigned PIPE_LAT = 2 * W + 1;
  localparam logic [W-1:0] RESET_MODULUS = 63'd1073807353;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef struct packed {
    logic vld;
    op_t  op;
  } ctrl_t;

  // Subtracts the modulus once when the value is at or above it.
  function automatic logic [W-1:0] cond_sub(input logic [W:0] x, input logic [W-1:0] m);
    logic [W:0] d;
    d = x - {1'b0, m};
    return (x >= {1'b0, m}) ? d[W-1:0] : x[W-1:0];
  endfunction

  // One step of interleaved modular multiplication: 2*acc (+ b) mod m.
  function automatic logic [W-1:0] mul_step(input logic [W-1:0] acc, input logic bit_a,
                                            input logic [W-1:0] b, input logic [W-1:0] m);
    logic [W-1:0] t;
    logic [W:0] u;
    t = cond_sub({acc, 1'b0}, m);
    u = {1'b0, t} + (bit_a ? {1'b0, b} : '0);
    return cond_sub(u, m);
  endfunction

endpackage

// ----- hw/rtl/maus_pipe.sv -----
// ----------------------------------------------------------------------------
// maus_pipe
// Operand reduction stages followed by bit-serial modular product stages.
// ----------------------------------------------------------------------------
module maus_pipe (
  input  logic                      clk,
  input  logic                      rst,
  input  maus_pkg::ctrl_t           in_ctrl,
  input  logic [maus_pkg::W-1:0]    in_a,
  input  logic [maus_pkg::W-1:0]    in_b,
  input  logic [maus_pkg::W-1:0]    modulus,
  output maus_pkg::ctrl_t           out_ctrl,
  output logic [maus_pkg::W-1:0]    out_a,
  output logic [maus_pkg::W-1:0]    out_b,
  output logic [maus_pkg::W-1:0]    out_prod
);

  maus_pkg::ctrl_t            ctrl [0:2*maus_pkg::W];
  logic [maus_pkg::W-1:0]     aq   [0:2*maus_pkg::W];
  logic [maus_pkg::W-1:0]     bq   [0:2*maus_pkg::W];
  logic [maus_pkg::W-1:0]     rawa [0:maus_pkg::W];
  logic [maus_pkg::W-1:0]     rawb [0:maus_pkg::W];
  logic [maus_pkg::W-1:0]     acc  [maus_pkg::W:2*maus_pkg::W];

  assign ctrl[0] = in_ctrl;
  assign aq[0] = '0;
  assign bq[0] = '0;
  assign rawa[0] = in_a;
  assign rawb[0] = in_b;
  assign acc[maus_pkg::W] = '0;

  for (genvar k = 0; k < 2 * maus_pkg::W; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        ctrl[k+1].vld <= 1'b0;
      end else begin
        ctrl[k+1].vld <= ctrl[k].vld;
      end
    end

    if (k < maus_pkg::W) begin : g_red
      always_ff @(posedge clk) begin
        ctrl[k+1].op <= ctrl[k].op;
        rawa[k+1] <= rawa[k];
        rawb[k+1] <= rawb[k];
        aq[k+1] <= maus_pkg::cond_sub({aq[k], rawa[k][maus_pkg::W-1-k]}, modulus);
        bq[k+1] <= maus_pkg::cond_sub({bq[k], rawb[k][maus_pkg::W-1-k]}, modulus);
      end
    end else begin : g_mul
      always_ff @(posedge clk) begin
        ctrl[k+1].op <= ctrl[k].op;
        aq[k+1] <= aq[k];
        bq[k+1] <= bq[k];
        acc[k+1] <= maus_pkg::mul_step(acc[k], aq[k][2*maus_pkg::W-1-k], bq[k], modulus);
      end
    end
  end

  assign out_ctrl = ctrl[2*maus_pkg::W];
  assign out_a = aq[2*maus_pkg::W];
  assign out_b = bq[2*maus_pkg::W];
  assign out_prod = acc[2*maus_pkg::W];

endmodule

// ----- hw/rtl/modular_add_sub_mul_unit_core.sv -----
// ----------------------------------------------------------------------------
// modular_add_sub_mul_unit_core
// Modular add, subtract and multiply of 63-bit residues.
// ----------------------------------------------------------------------------
// A request is taken in every cycle outside reset and its residue appears on
// residue, marked by done. 63 stages reduce both operands one bit per stage,
// 63 stages form the product one bit of the first operand per stage, and one
// stage selects and registers the result. The receiver cannot stall the unit:
// each result is present only in the one cycle in which done is high. The
// modulus may be written only when no request is in flight.
module modular_add_sub_mul_unit_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                op,
  input  logic [maus_pkg::W-1:0]    operand_a,
  input  logic [maus_pkg::W-1:0]    operand_b,
  output logic                      done,
  output logic [maus_pkg::W-1:0]    residue,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [maus_pkg::W-1:0]    cfg_data
);

  logic [maus_pkg::W-1:0] modulus;
  maus_pkg::ctrl_t        in_ctrl;
  maus_pkg::ctrl_t        p_ctrl;
  logic [maus_pkg::W-1:0] p_a;
  logic [maus_pkg::W-1:0] p_b;
  logic [maus_pkg::W-1:0] p_prod;
  logic [maus_pkg::W-1:0] residue_next;
  logic [maus_pkg::W-1:0] diff;

  assign busy = rst;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= maus_pkg::RESET_MODULUS;
    end else if (cfg_valid && cfg_ready && cfg_data >= maus_pkg::W'(2)) begin
      modulus <= cfg_data;
    end
  end

  assign in_ctrl.vld = start && !busy;
  assign in_ctrl.op = maus_pkg::op_t'(op);

  maus_pipe u_pipe (
    .clk     (clk),
    .rst     (rst),
    .in_ctrl (in_ctrl),
    .in_a    (operand_a),
    .in_b    (operand_b),
    .modulus (modulus),
    .out_ctrl(p_ctrl),
    .out_a   (p_a),
    .out_b   (p_b),
    .out_prod(p_prod)
  );

  assign diff = p_a - p_b;

  always_comb begin
    case (p_ctrl.op)
      maus_pkg::OP_ADD: residue_next = maus_pkg::cond_sub({1'b0, p_a} + {1'b0, p_b}, modulus);
      maus_pkg::OP_SUB: residue_next = (p_a < p_b) ? diff + modulus : diff;
      maus_pkg::OP_MUL: residue_next = p_prod;
      default:          residue_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p_ctrl.vld;
    end
    residue <= residue_next;
  end

  a_done_follows_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, maus_pkg::PIPE_LAT))
    else $error("Result without a matching request.");

  a_residue_reduced: assert property (@(posedge clk) disable iff (rst)
    done |-> residue < modulus)
    else $error("Residue not below the modulus.");

  a_small_modulus_ignored: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_data < maus_pkg::W'(2) |=> $stable(modulus))
    else $error("Modulus below two was taken.");

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the modular add, subtract and multiply core.
// Requests are sent under random gaps and checked in order against a
// predictor that keeps its own modulus. The modulus is rewritten between
// phases while the core is idle, including the extremes and ignored writes.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned W = maus_pkg::W;

  typedef struct {
    maus_pkg::op_t op;
    logic [W-1:0]  a;
    logic [W-1:0]  b;
    bit            known;
    logic [W-1:0]  res;
  } req_row_t;

  localparam logic [W-1:0] MAXV = {W{1'b1}};
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] op = 2'd0;
  logic [W-1:0] operand_a = '0;
  logic [W-1:0] operand_b = '0;
  logic cfg_valid = 1'b0;
  logic [W-1:0] cfg_data = '0;
  logic busy, done, cfg_ready;
  logic [W-1:0] residue;
  logic busy_n, cfg_ready_n;

  logic [W-1:0] cur_modulus;
  logic [W-1:0] residue_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit activity;
  req_row_t rows[$];

  modular_add_sub_mul_unit_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .operand_a(operand_a), .operand_b(operand_b), .done(done),
    .residue(residue), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Handshake inputs cannot move between the falling and the next rising edge.
  always @(negedge clk) begin
    busy_n <= busy;
    cfg_ready_n <= cfg_ready;
  end

  function automatic logic [W-1:0] mod_result(maus_pkg::op_t o, logic [W-1:0] a,
                                              logic [W-1:0] b, logic [W-1:0] m);
    logic [W-1:0] ra, rb;
    logic [W:0] s;
    logic [2*W-1:0] p;
    ra = a % m;
    rb = b % m;
    case (o)
      maus_pkg::OP_ADD: begin
        s = {1'b0, ra} + {1'b0, rb};
        if (s >= {1'b0, m}) s = s - {1'b0, m};
        return s[W-1:0];
      end
      maus_pkg::OP_SUB: begin
        s = {1'b0, ra} - {1'b0, rb};
        if (ra < rb) s = s + {1'b0, m};
        return s[W-1:0];
      end
      maus_pkg::OP_MUL: begin
        p = {{W{1'b0}}, ra} * {{W{1'b0}}, rb};
        p = p % {{W{1'b0}}, m};
        return p[W-1:0];
      end
      default: return '0;
    endcase
  endfunction

  function automatic logic [W-1:0] rand63();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      activity = done || (start && !busy_n) || (cfg_valid && cfg_ready_n);
      idle_cycles = activity ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
      if (done) begin
        if (residue_q.size() == 0) begin
          $error("residue: no request outstanding, actual %0d", residue);
          errors++;
        end else begin
          if (residue !== residue_q[0]) begin
            $error("residue: expected %0d actual %0d", residue_q[0], residue);
            errors++;
          end
          void'(residue_q.pop_front());
        end
      end
    end
  end

  task automatic send_req(maus_pkg::op_t o, logic [W-1:0] a, logic [W-1:0] b, bit known,
                          logic [W-1:0] res);
    int gap;
    gap = $urandom_range(7);
    if ($urandom_range(3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    op <= o;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (busy_n);
    residue_q.push_back(known ? res : mod_result(o, a, b, cur_modulus));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (residue_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_modulus(logic [W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready_n);
    cfg_valid <= 1'b0;
    if (v >= 2) cur_modulus = v;
    @(posedge clk);
  endtask

  task automatic random_phase(int n);
    logic [W-1:0] a, b;
    maus_pkg::op_t o;
    for (int i = 0; i < n; i++) begin
      o = ($urandom_range(8) == 0) ? maus_pkg::OP_NONE
                                   : maus_pkg::op_t'(2'($urandom_range(2)));
      a = rand63();
      b = rand63();
      case ($urandom_range(9))
        0: ;
        1: begin a = cur_modulus - 1; b = cur_modulus - 1 - (b % 2); end
        2: begin a = a % 2; b = b % cur_modulus; end
        default: begin a = a % cur_modulus; b = b % cur_modulus; end
      endcase
      send_req(o, a, b, 1'b0, '0);
      if (i == n / 2 && $urandom_range(1)) drain();
    end
  endtask

  initial begin
    logic [W-1:0] m0;
    m0 = maus_pkg::RESET_MODULUS;
    cur_modulus = maus_pkg::RESET_MODULUS;
    rows = '{
      '{maus_pkg::OP_ADD, m0 - 1, m0 - 1, 1'b1, m0 - 2},
      '{maus_pkg::OP_ADD, '0, '0, 1'b1, '0},
      '{maus_pkg::OP_ADD, m0 - 1, 63'd1, 1'b1, '0},
      '{maus_pkg::OP_SUB, '0, 63'd1, 1'b1, m0 - 1},
      '{maus_pkg::OP_SUB, m0 - 1, m0 - 1, 1'b1, '0},
      '{maus_pkg::OP_SUB, m0 - 1, '0, 1'b1, m0 - 1},
      '{maus_pkg::OP_MUL, m0 - 1, m0 - 1, 1'b1, 63'd1},
      '{maus_pkg::OP_MUL, '0, m0 - 1, 1'b1, '0},
      '{maus_pkg::OP_MUL, 63'd1, m0 - 1, 1'b1, m0 - 1},
      '{maus_pkg::OP_NONE, MAXV, MAXV, 1'b1, '0},
      '{maus_pkg::OP_NONE, '0, '0, 1'b1, '0},
      '{maus_pkg::OP_ADD, MAXV, MAXV, 1'b0, '0},
      '{maus_pkg::OP_SUB, m0, MAXV, 1'b0, '0},
      '{maus_pkg::OP_MUL, MAXV, MAXV - 1, 1'b0, '0},
      '{maus_pkg::OP_MUL, 63'h2AAAAAAAAAAAAAAA, 63'h5555555555555555, 1'b0, '0}
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) send_req(rows[i].op, rows[i].a, rows[i].b, rows[i].known, rows[i].res);

    write_modulus(63'd2);
    send_req(maus_pkg::OP_ADD, 63'd1, 63'd1, 1'b1, '0);
    send_req(maus_pkg::OP_MUL, 63'd1, 63'd1, 1'b1, 63'd1);
    random_phase(80);
    write_modulus(MAXV);
    send_req(maus_pkg::OP_MUL, MAXV - 1, MAXV - 1, 1'b1, 63'd1);
    send_req(maus_pkg::OP_ADD, MAXV - 1, MAXV - 1, 1'b1, MAXV - 2);
    random_phase(130);
    write_modulus('0);
    write_modulus(63'd1);
    random_phase(60);
    write_modulus(63'd3);
    random_phase(80);
    write_modulus(rand63() | 63'h4000000000000000);
    random_phase(130);
    write_modulus(({$urandom} & 32'hFFFFF) | 63'd2);
    random_phase(100);
    write_modulus(rand63() | 63'd2);
    random_phase(100);
    write_modulus(maus_pkg::RESET_MODULUS);
    random_phase(70);

    drain();
    repeat (140) @(posedge clk);
    if (errors == 0 && residue_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ----- files.f -----
hw/rtl/maus_pkg.sv
hw/rtl/maus_pipe.sv
hw/rtl/modular_add_sub_mul_unit_core.sv
tb/sv/tb.sv
